// ===== sv/spq_pkg.sv =====
// Shared types, codes and helpers of the stable priority queue.
`default_nettype none

package spq_pkg;

  // Priority field: 1 is the highest, 5 the lowest.
  localparam int unsigned PrioBits = 3;
  localparam logic [PrioBits-1:0] PrioHighest = 3'd1;
  localparam logic [PrioBits-1:0] PrioLowest  = 3'd5;

  // Request mode.
  localparam logic ModeEnqueue = 1'b0;
  localparam logic ModeDequeue = 1'b1;

  typedef enum logic [2:0] {
    StatusEnqueued  = 3'd0,
    StatusDequeued  = 3'd1,
    StatusDuplicate = 3'd2,
    StatusFull      = 3'd3,
    StatusEmpty     = 3'd4
  } status_e;

  // Zero maps to the highest priority, six and seven to the lowest.
  function automatic logic [PrioBits-1:0] clamp_prio(logic [PrioBits-1:0] p);
    logic [PrioBits-1:0] v;
    v = p;
    if (p < PrioHighest) v = PrioHighest;
    if (p > PrioLowest)  v = PrioLowest;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/spq_if.sv =====
// Request and response channel interfaces of the stable priority queue.
`default_nettype none

interface spq_req_if #(
  parameter int unsigned ID_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ID_BITS-1:0]            process_id;
  logic [spq_pkg::PrioBits-1:0]  priority_req;

  modport source (output valid, mode, process_id, priority_req, input ready);
  modport sink   (input valid, mode, process_id, priority_req, output ready);
endinterface

interface spq_rsp_if #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned CNT_BITS = 5
);
  logic                          valid;
  logic                          ready;
  spq_pkg::status_e              status;
  logic [ID_BITS-1:0]            out_id;
  logic [spq_pkg::PrioBits-1:0]  out_priority;
  logic [CNT_BITS-1:0]           occupancy;

  modport source (output valid, status, out_id, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

`default_nettype wire

// ===== sv/stable_priority_queue_top.sv =====
// Enqueue: scan, move each entry behind the insert position up a slot (read, then write),
// insert, finish; a duplicate ends at the match, a full queue at its last entry. Dequeue
// reads the front entry, moves each later one down a slot; an empty one goes to finish.
// One request at a time; the next is taken once the result enters a free output register.
// Reset clears the state machine, the entry count and the output valid; slot contents
// stay undefined and need no clearing pass, since only slots below the count are used.
`default_nettype none

module stable_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  spq_req_if.sink          req_i,
  spq_rsp_if.source        rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);      // slot address bits
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);  // count bits, holds the depth
  localparam int unsigned PW = spq_pkg::PrioBits;

  // Sequencer, one-hot.
  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,  // waiting for a request
    StScan   = 9'b000000010,  // walk slots: duplicate check and insert position
    StShuRd  = 9'b000000100,  // enqueue: read slot dst-1
    StShuWr  = 9'b000001000,  // enqueue: write it to slot dst
    StInsert = 9'b000010000,  // write the new entry at its position
    StDqHead = 9'b000100000,  // dequeue: front entry is on the read port
    StShdRd  = 9'b001000000,  // dequeue: read slot dst+1
    StShdWr  = 9'b010000000,  // dequeue: write it to slot dst
    StFinish = 9'b100000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // Entry count and output register.
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  spq_pkg::status_e out_status_q;
  logic [ID_BITS-1:0] out_id_q;
  logic [PW-1:0]    out_pri_q;
  logic [CW-1:0]    out_occ_q;

  // Latched request.
  logic [ID_BITS-1:0] id_q, id_d;
  logic [PW-1:0]      pri_q, pri_d;

  // Scan and shift bookkeeping.
  logic [CW-1:0] idx_q, idx_d;          // next slot the scan reads
  logic          chk_q, chk_d;          // read data holds slot chk_idx
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic          found_q, found_d;      // a worse priority has been seen
  logic [CW-1:0] pos_q, pos_d;          // insert position
  logic [CW-1:0] dst_q, dst_d;          // shift destination

  // Pending result.
  spq_pkg::status_e   res_status_q, res_status_d;
  logic [ID_BITS-1:0] res_id_q, res_id_d;
  logic [PW-1:0]      res_pri_q, res_pri_d;
  logic [CW-1:0]      res_cnt_q, res_cnt_d;

  // Slot memory: one write port, one registered read port.
  logic [ID_BITS-1:0] id_mem  [QUEUE_DEPTH];
  logic [PW-1:0]      pri_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_id_q;
  logic [PW-1:0]      rd_pri_q;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ID_BITS-1:0] wid;
  logic [PW-1:0]      wpri;

  always_ff @(posedge clk_i) begin
    if (we) begin
      id_mem[waddr]  <= wid;
      pri_mem[waddr] <= wpri;
    end
    rd_id_q  <= id_mem[raddr];
    rd_pri_q <= pri_mem[raddr];
  end

  logic          req_fire;
  logic          out_free;
  logic          hit;
  logic          worse;
  logic          last;
  logic [CW-1:0] pos_final;
  logic [CW-1:0] dst_m1;
  logic [CW-1:0] dst_p1;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign dst_m1   = dst_q - CW'(1);
  assign dst_p1   = dst_q + CW'(1);

  // Compare on the slot currently on the read port (scan only).
  assign hit       = chk_q && (rd_id_q == id_q);
  assign worse     = chk_q && (rd_pri_q > pri_q);
  assign last      = chk_q && ((chk_idx_q + CW'(1)) == cnt_q);
  assign pos_final = (worse && !found_q) ? chk_idx_q : pos_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    id_d         = id_q;
    pri_d        = pri_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    pos_d        = pos_q;
    dst_d        = dst_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_pri_d    = res_pri_q;
    res_cnt_d    = res_cnt_q;
    raddr        = '0;  // idle reads the front slot, ready for a dequeue
    we           = 1'b0;
    waddr        = pos_q[AW-1:0];
    wid          = id_q;
    wpri         = pri_q;

    if (rsp_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          id_d      = req_i.process_id;
          pri_d     = spq_pkg::clamp_prio(req_i.priority_req);
          res_id_d  = '0;
          res_pri_d = '0;
          res_cnt_d = cnt_q;
          if (req_i.mode == spq_pkg::ModeDequeue) begin
            if (cnt_q == '0) begin
              res_status_d = spq_pkg::StatusEmpty;
              state_d      = StFinish;
            end else begin
              state_d = StDqHead;
            end
          end else if (cnt_q == '0) begin
            pos_d   = '0;
            state_d = StInsert;
          end else begin
            idx_d   = '0;
            chk_d   = 1'b0;
            found_d = 1'b0;
            pos_d   = cnt_q;
            state_d = StScan;
          end
        end
      end

      StScan: begin
        raddr = idx_q[AW-1:0];
        if (idx_q < cnt_q) begin
          idx_d     = idx_q + CW'(1);
          chk_d     = 1'b1;
          chk_idx_d = idx_q;
        end else begin
          chk_d = 1'b0;
        end
        if (worse && !found_q) begin
          found_d = 1'b1;
          pos_d   = chk_idx_q;
        end
        // Duplicate check wins over the full check.
        if (hit) begin
          res_status_d = spq_pkg::StatusDuplicate;
          state_d      = StFinish;
        end else if (last) begin
          if (cnt_q == CW'(QUEUE_DEPTH)) begin
            res_status_d = spq_pkg::StatusFull;
            state_d      = StFinish;
          end else begin
            pos_d   = pos_final;
            dst_d   = cnt_q;
            state_d = (pos_final == cnt_q) ? StInsert : StShuRd;
          end
        end
      end

      StShuRd: begin
        raddr   = dst_m1[AW-1:0];
        state_d = StShuWr;
      end

      StShuWr: begin
        we      = 1'b1;
        waddr   = dst_q[AW-1:0];
        wid     = rd_id_q;
        wpri    = rd_pri_q;
        dst_d   = dst_m1;
        state_d = (dst_m1 == pos_q) ? StInsert : StShuRd;
      end

      StInsert: begin
        we           = 1'b1;
        waddr        = pos_q[AW-1:0];
        res_status_d = spq_pkg::StatusEnqueued;
        res_cnt_d    = cnt_q + CW'(1);
        state_d      = StFinish;
      end

      StDqHead: begin
        res_status_d = spq_pkg::StatusDequeued;
        res_id_d     = rd_id_q;
        res_pri_d    = rd_pri_q;
        res_cnt_d    = cnt_q - CW'(1);
        dst_d        = '0;
        state_d      = (cnt_q == CW'(1)) ? StFinish : StShdRd;
      end

      StShdRd: begin
        raddr   = dst_p1[AW-1:0];
        state_d = StShdWr;
      end

      StShdWr: begin
        we      = 1'b1;
        waddr   = dst_q[AW-1:0];
        wid     = rd_id_q;
        wpri    = rd_pri_q;
        dst_d   = dst_p1;
        state_d = ((dst_q + CW'(2)) == cnt_q) ? StFinish : StShdRd;
      end

      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cnt_d       = res_cnt_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scratch registers, always written before use.
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    pri_q        <= pri_d;
    idx_q        <= idx_d;
    chk_q        <= chk_d;
    chk_idx_q    <= chk_idx_d;
    found_q      <= found_d;
    pos_q        <= pos_d;
    dst_q        <= dst_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_pri_q    <= res_pri_d;
    res_cnt_q    <= res_cnt_d;
    if ((state_q == StFinish) && out_free) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_pri_q    <= res_pri_q;
      out_occ_q    <= res_cnt_q;
    end
  end

  assign req_i.ready        = (state_q == StIdle);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.out_id       = out_id_q;
  assign rsp_o.out_priority = out_pri_q;
  assign rsp_o.occupancy    = out_occ_q;

endmodule

`default_nettype wire
